// ===== rtl/core/pmt_pkg.sv =====
// Package for the paged memory unit: sizes, FSM state type and the
// command/status structs between controller and datapath. No dependencies.
package pmt_pkg;

    localparam int FRAMES      = 64;
    localparam int PAGES       = 128;
    localparam int PROCESSES   = 16;
    localparam int TLB_ENTRIES = 8;
    localparam int SWAP_SLOTS  = 256;
    localparam int PAGE_BYTES  = 4096;

    localparam int PROC_W   = 4;
    localparam int PAGE_W   = 7;
    localparam int OFFS_W   = 12;
    localparam int FRAME_W  = 6;
    localparam int PADDR_W  = 18;
    localparam int CNT_W    = 9;
    localparam int WIN_W    = 8;
    localparam int CFG_W    = 8;

    localparam logic [0:0] REG_FAULT_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_INITIAL_WINDOW  = 1'b1;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_SOFT = 2'd1;
    localparam logic [1:0] FAULT_HARD = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_PT,
        ST_SCAN,
        ST_VICTIM,
        ST_EVICT,
        ST_FILL,
        ST_DONE
    } pmt_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear_step;   // advance clearing pass
        logic load;         // latch accepted item
        logic tlb_search;   // search TLB, read page-table row
        logic pt_check;     // evaluate page-table entry, fault bookkeeping
        logic scan_step;    // test one frame for being free
        logic victim_read;  // read victim slot's frame and swap bit
        logic evict;        // evict victim
        logic fill;         // write page table, FIFO, TLB, window
    } pmt_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic tlb_hit;
        logic pt_valid;
        logic scan_found;
        logic scan_last;
        logic fifo_empty;
    } pmt_sts_t;

endpackage

// ===== rtl/core/pmt_ctrl.sv =====
// Controller state machine of the paged memory unit.
// Depends on pmt_pkg for the state type and command/status structs.
module pmt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pmt_pkg::pmt_sts_t sts,
    output pmt_pkg::pmt_cmd_t cmd
);

    pmt_pkg::pmt_state_t state_reg, state_next;

    // Advance state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmt_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pmt_pkg::ST_CLEAR:  if (sts.clear_done) state_next = pmt_pkg::ST_IDLE;
            pmt_pkg::ST_IDLE:   if (s_valid) state_next = pmt_pkg::ST_LOOKUP;
            pmt_pkg::ST_LOOKUP: state_next = pmt_pkg::ST_PT;
            pmt_pkg::ST_PT: begin
                if (sts.tlb_hit || sts.pt_valid) begin
                    state_next = pmt_pkg::ST_FILL;
                end else begin
                    state_next = pmt_pkg::ST_SCAN;
                end
            end
            pmt_pkg::ST_SCAN: begin
                if (sts.scan_found) begin
                    state_next = pmt_pkg::ST_FILL;
                end else if (sts.scan_last) begin
                    state_next = sts.fifo_empty ? pmt_pkg::ST_FILL : pmt_pkg::ST_VICTIM;
                end
            end
            pmt_pkg::ST_VICTIM: state_next = pmt_pkg::ST_EVICT;
            pmt_pkg::ST_EVICT:  state_next = pmt_pkg::ST_FILL;
            pmt_pkg::ST_FILL:   state_next = pmt_pkg::ST_DONE;
            pmt_pkg::ST_DONE:   if (m_ready) state_next = pmt_pkg::ST_IDLE;
            default:            state_next = pmt_pkg::ST_CLEAR;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            pmt_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
            pmt_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            pmt_pkg::ST_LOOKUP: cmd.tlb_search = 1'b1;
            pmt_pkg::ST_PT:     cmd.pt_check = 1'b1;
            pmt_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
            pmt_pkg::ST_VICTIM: cmd.victim_read = 1'b1;
            pmt_pkg::ST_EVICT:  cmd.evict = 1'b1;
            pmt_pkg::ST_FILL:   cmd.fill = 1'b1;
            pmt_pkg::ST_DONE: begin
                m_valid = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/pmt_dp.sv =====
// Datapath of the paged memory unit: page-table, FIFO and frame memories,
// TLB, per-process counters and result registers. Depends on pmt_pkg.
module pmt_dp #(
    parameter int FRAMES      = pmt_pkg::FRAMES,
    parameter int PAGES       = pmt_pkg::PAGES,
    parameter int PROCESSES   = pmt_pkg::PROCESSES,
    parameter int TLB_ENTRIES = pmt_pkg::TLB_ENTRIES,
    parameter int SWAP_SLOTS  = pmt_pkg::SWAP_SLOTS,
    parameter int PAGE_BYTES  = pmt_pkg::PAGE_BYTES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pmt_pkg::pmt_cmd_t            cmd,
    output pmt_pkg::pmt_sts_t            sts,
    input  logic                         cfg_valid,
    input  logic [0:0]                   cfg_index,
    input  logic [pmt_pkg::CFG_W-1:0]    cfg_data,
    input  logic [pmt_pkg::PROC_W-1:0]   in_proc,
    input  logic [pmt_pkg::PAGE_W-1:0]   in_page,
    input  logic [pmt_pkg::OFFS_W-1:0]   in_offset,
    output logic [pmt_pkg::FRAME_W-1:0]  out_frame,
    output logic [pmt_pkg::PADDR_W-1:0]  out_phys_addr,
    output logic                         out_tlb_hit,
    output logic [1:0]                   out_fault_kind,
    output logic                         out_evicted,
    output logic [pmt_pkg::PROC_W-1:0]   out_evicted_process,
    output logic [pmt_pkg::PAGE_W-1:0]   out_evicted_page,
    output logic                         out_victim_saved,
    output logic                         out_window_grew,
    output logic [pmt_pkg::WIN_W-1:0]    out_window_size
);

    localparam int SLOTS = PROCESSES * PAGES;
    localparam int PR_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PG_W  = $clog2(PAGES);
    localparam int SL_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FR_W  = $clog2(FRAMES);
    localparam int TL_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int OF_W  = $clog2(PAGE_BYTES);
    localparam int SW_W  = $clog2(SWAP_SLOTS + 1);
    localparam int FC_W  = $clog2(FRAMES + 1);
    localparam int CW    = pmt_pkg::CNT_W;
    localparam int WW    = pmt_pkg::WIN_W;

    // Memories: page table entry {valid, in_swap, frame}, FIFO of slots.
    logic [FR_W+1:0] pt_mem [SLOTS];
    logic [SL_W-1:0] fifo_mem [FRAMES];
    logic            fused_mem [FRAMES];

    // Config.
    logic [WW-1:0] thresh_reg;

    // Item.
    logic [PR_W-1:0] proc_reg;
    logic [PG_W-1:0] page_reg;
    logic [OF_W-1:0] offs_reg;
    logic [SL_W-1:0] slot;
    assign slot = SL_W'({proc_reg, page_reg});

    // TLB.
    logic            tlb_v_reg   [TLB_ENTRIES];
    logic [PR_W-1:0] tlb_p_reg   [TLB_ENTRIES];
    logic [PG_W-1:0] tlb_g_reg   [TLB_ENTRIES];
    logic [FR_W-1:0] tlb_f_reg   [TLB_ENTRIES];
    logic [TL_W-1:0] tlb_ptr_reg;

    // Control and bookkeeping state.
    logic [FR_W-1:0] fifo_head_reg;
    logic [FC_W-1:0] fifo_cnt_reg;
    logic [SW_W-1:0] swap_cnt_reg;
    logic [CW-1:0]   fcnt_reg [PROCESSES];
    logic [WW-1:0]   win_reg  [PROCESSES];
    logic [SL_W:0]   clr_reg;
    logic [FR_W:0]   scan_reg;

    // Work registers.
    logic [FR_W+1:0] pt_rd_reg;
    logic [FR_W+1:0] vpt_rd_reg;
    logic            fu_rd_reg;
    logic [SL_W-1:0] vslot_reg;
    logic            hit_reg;
    logic [FR_W-1:0] hit_frame_reg;
    logic [FR_W-1:0] new_frame_reg;
    logic            fault_reg;

    // TLB search (parallel compare over entries).
    logic            tlb_match;
    logic [FR_W-1:0] tlb_match_frame;
    always_comb begin
        tlb_match       = 1'b0;
        tlb_match_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (tlb_v_reg[i] && tlb_p_reg[i] == proc_reg && tlb_g_reg[i] == page_reg) begin
                tlb_match       = 1'b1;
                tlb_match_frame = tlb_f_reg[i];
            end
        end
    end

    logic [FR_W-1:0] fifo_tail;
    assign fifo_tail = FR_W'((FC_W+1)'(fifo_head_reg) + (FC_W+1)'(fifo_cnt_reg));

    // Status.
    assign sts.clear_done = (clr_reg == (SL_W+1)'(SLOTS - 1));
    assign sts.tlb_hit    = hit_reg;
    assign sts.pt_valid   = pt_rd_reg[FR_W+1];
    assign sts.scan_found = !fu_rd_reg && scan_reg != '0;
    assign sts.scan_last  = (scan_reg == (FR_W+1)'(FRAMES));
    assign sts.fifo_empty = (fifo_cnt_reg == '0);

    // Page-table memory: clear pass, reads, writes.
    logic [FR_W+1:0] fill_entry;
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            pt_mem[clr_reg[SL_W-1:0]] <= '0;
        end else if (cmd.evict) begin
            pt_mem[vslot_reg] <= {1'b0, vpt_rd_reg[FR_W] || (swap_cnt_reg < SW_W'(SWAP_SLOTS)),
                                  vpt_rd_reg[FR_W-1:0]};
        end else if (cmd.fill && !hit_reg && fault_reg) begin
            pt_mem[slot] <= fill_entry;
        end
        if (cmd.tlb_search) begin
            pt_rd_reg <= pt_mem[slot];
        end
        if (cmd.victim_read) begin
            vpt_rd_reg <= pt_mem[vslot_reg];
        end
    end
    assign fill_entry = {1'b1, 1'b0, new_frame_reg};

    // FIFO memory.
    always_ff @(posedge aclk) begin
        if (cmd.fill && !hit_reg && fault_reg && fifo_cnt_reg < FC_W'(FRAMES)) begin
            fifo_mem[fifo_tail] <= slot;
        end
        if (cmd.pt_check) begin
            vslot_reg <= fifo_mem[fifo_head_reg];
        end
    end

    // Frame-used memory, swept one frame per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.clear_step && clr_reg < (SL_W+1)'(FRAMES)) begin
            fused_mem[clr_reg[FR_W-1:0]] <= 1'b0;
        end else if (cmd.scan_step && !sts.scan_found && !sts.scan_last) begin
            fused_mem[scan_reg[FR_W-1:0]] <= 1'b1;
        end
        if (cmd.scan_step && !sts.scan_last) begin
            fu_rd_reg <= fused_mem[scan_reg[FR_W-1:0]];
        end else if (cmd.pt_check) begin
            fu_rd_reg <= 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg    <= pmt_pkg::CFG_W'(5);
            tlb_ptr_reg   <= '0;
            fifo_head_reg <= '0;
            fifo_cnt_reg  <= '0;
            swap_cnt_reg  <= '0;
            clr_reg       <= '0;
            scan_reg      <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) tlb_v_reg[i] <= 1'b0;
            for (int i = 0; i < PROCESSES; i++) begin
                fcnt_reg[i] <= '0;
                win_reg[i]  <= WW'(10);
            end
        end else begin
            // Configuration writes.
            if (cfg_valid) begin
                if (cfg_index == pmt_pkg::REG_FAULT_THRESHOLD) begin
                    thresh_reg <= cfg_data;
                end else begin
                    for (int i = 0; i < PROCESSES; i++) win_reg[i] <= cfg_data;
                end
            end
            if (cmd.clear_step && !sts.clear_done) clr_reg <= clr_reg + 1'b1;
            if (cmd.pt_check) scan_reg <= '0;
            if (cmd.scan_step && !sts.scan_last) scan_reg <= scan_reg + 1'b1;
            // Fault: count it and take page from swap.
            if (cmd.pt_check && !hit_reg && !pt_rd_reg[FR_W+1]) begin
                if (fcnt_reg[proc_reg] != '1) fcnt_reg[proc_reg] <= fcnt_reg[proc_reg] + 1'b1;
                if (pt_rd_reg[FR_W] && swap_cnt_reg != '0) swap_cnt_reg <= swap_cnt_reg - 1'b1;
            end
            // Eviction: pop FIFO, save in swap, drop TLB entry.
            if (cmd.evict) begin
                fifo_head_reg <= fifo_head_reg + 1'b1;
                fifo_cnt_reg  <= fifo_cnt_reg - 1'b1;
                if (!vpt_rd_reg[FR_W] && swap_cnt_reg < SW_W'(SWAP_SLOTS)) begin
                    swap_cnt_reg <= swap_cnt_reg + 1'b1;
                end
                for (int i = 0; i < TLB_ENTRIES; i++) begin
                    if (tlb_v_reg[i] && SL_W'({tlb_p_reg[i], tlb_g_reg[i]}) == vslot_reg) begin
                        tlb_v_reg[i] <= 1'b0;
                    end
                end
            end
            // Fill: push FIFO, load TLB, update window.
            if (cmd.fill) begin
                if (!hit_reg) begin
                    if (fault_reg && fifo_cnt_reg < FC_W'(FRAMES)) begin
                        fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
                    end
                    tlb_v_reg[tlb_ptr_reg] <= 1'b1;
                    tlb_p_reg[tlb_ptr_reg] <= proc_reg;
                    tlb_g_reg[tlb_ptr_reg] <= page_reg;
                    tlb_f_reg[tlb_ptr_reg] <= new_frame_reg;
                    tlb_ptr_reg <= (tlb_ptr_reg == TL_W'(TLB_ENTRIES - 1)) ? '0
                                   : tlb_ptr_reg + 1'b1;
                end
                if (fcnt_reg[proc_reg] > CW'(thresh_reg)) begin
                    if (win_reg[proc_reg] != '1) win_reg[proc_reg] <= win_reg[proc_reg] + 1'b1;
                    fcnt_reg[proc_reg] <= '0;
                end
            end
        end
    end

    // Item and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            proc_reg            <= PR_W'(in_proc % PROCESSES);
            page_reg            <= PG_W'(in_page);
            offs_reg            <= OF_W'(in_offset);
            out_evicted         <= 1'b0;
            out_evicted_process <= '0;
            out_evicted_page    <= '0;
            out_victim_saved    <= 1'b0;
            out_fault_kind      <= pmt_pkg::FAULT_NONE;
        end
        if (cmd.tlb_search) begin
            hit_reg       <= tlb_match;
            hit_frame_reg <= tlb_match_frame;
        end
        if (cmd.pt_check) begin
            fault_reg     <= !hit_reg && !pt_rd_reg[FR_W+1];
            new_frame_reg <= hit_reg ? hit_frame_reg : pt_rd_reg[FR_W-1:0];
            if (!hit_reg && !pt_rd_reg[FR_W+1]) begin
                out_fault_kind <= pt_rd_reg[FR_W] ? pmt_pkg::FAULT_SOFT : pmt_pkg::FAULT_HARD;
                new_frame_reg  <= '0;
            end
        end
        if (cmd.scan_step && sts.scan_found) begin
            new_frame_reg <= FR_W'(scan_reg - 1'b1);
        end
        if (cmd.evict) begin
            new_frame_reg       <= vpt_rd_reg[FR_W-1:0];
            out_evicted         <= 1'b1;
            out_evicted_process <= pmt_pkg::PROC_W'(vslot_reg[SL_W-1:PG_W]);
            out_evicted_page    <= pmt_pkg::PAGE_W'(vslot_reg[PG_W-1:0]);
            out_victim_saved    <= vpt_rd_reg[FR_W] || (swap_cnt_reg < SW_W'(SWAP_SLOTS));
        end
        if (cmd.fill) begin
            out_frame       <= pmt_pkg::FRAME_W'(new_frame_reg);
            out_phys_addr   <= pmt_pkg::PADDR_W'({new_frame_reg, offs_reg});
            out_tlb_hit     <= hit_reg;
            out_window_grew <= fcnt_reg[proc_reg] > CW'(thresh_reg);
            out_window_size <= (fcnt_reg[proc_reg] > CW'(thresh_reg) && win_reg[proc_reg] != '1)
                               ? win_reg[proc_reg] + 1'b1 : win_reg[proc_reg];
        end
    end

endmodule

// ===== rtl/core/paged_mmu_tlb_fifo_swap_core.sv =====
// Top level of the paged memory unit: controller and datapath.
// Depends on pmt_pkg, pmt_ctrl and pmt_dp.
//
// One item at a time. A TLB hit or a page-table hit passes through the
// lookup, page-table and fill states before its result shows; a fault scans
// the frame-used memory one frame per cycle, stopping at the lowest free
// frame, and an eviction adds the victim-read and evict states. After reset
// a clearing pass runs through the page table before the first item is
// accepted; write configuration only while no item is in flight.
module paged_mmu_tlb_fifo_swap_core #(
    parameter int FRAMES      = pmt_pkg::FRAMES,
    parameter int PAGES       = pmt_pkg::PAGES,
    parameter int PROCESSES   = pmt_pkg::PROCESSES,
    parameter int TLB_ENTRIES = pmt_pkg::TLB_ENTRIES,
    parameter int SWAP_SLOTS  = pmt_pkg::SWAP_SLOTS,
    parameter int PAGE_BYTES  = pmt_pkg::PAGE_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [0:0]                  cfg_index,
    input  logic [pmt_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pmt_pkg::PROC_W-1:0]  s_process_index,
    input  logic [pmt_pkg::PAGE_W-1:0]  s_page,
    input  logic [pmt_pkg::OFFS_W-1:0]  s_offset,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pmt_pkg::FRAME_W-1:0] m_frame,
    output logic [pmt_pkg::PADDR_W-1:0] m_phys_addr,
    output logic                        m_tlb_hit,
    output logic [1:0]                  m_fault_kind,
    output logic                        m_evicted,
    output logic [pmt_pkg::PROC_W-1:0]  m_evicted_process,
    output logic [pmt_pkg::PAGE_W-1:0]  m_evicted_page,
    output logic                        m_victim_saved,
    output logic                        m_window_grew,
    output logic [pmt_pkg::WIN_W-1:0]   m_window_size
);

    pmt_pkg::pmt_cmd_t cmd;
    pmt_pkg::pmt_sts_t sts;

    assign cfg_ready = 1'b1;

    pmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pmt_dp #(
        .FRAMES      (FRAMES),
        .PAGES       (PAGES),
        .PROCESSES   (PROCESSES),
        .TLB_ENTRIES (TLB_ENTRIES),
        .SWAP_SLOTS  (SWAP_SLOTS),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_proc             (s_process_index),
        .in_page             (s_page),
        .in_offset           (s_offset),
        .out_frame           (m_frame),
        .out_phys_addr       (m_phys_addr),
        .out_tlb_hit         (m_tlb_hit),
        .out_fault_kind      (m_fault_kind),
        .out_evicted         (m_evicted),
        .out_evicted_process (m_evicted_process),
        .out_evicted_page    (m_evicted_page),
        .out_victim_saved    (m_victim_saved),
        .out_window_grew     (m_window_grew),
        .out_window_size     (m_window_size)
    );

    // A TLB hit never faults or evicts.
    a_hit_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tlb_hit |-> m_fault_kind == pmt_pkg::FAULT_NONE && !m_evicted)
        else $error("TLB hit reported with fault");

    // Eviction happens only on a fault.
    a_evict_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> m_fault_kind != pmt_pkg::FAULT_NONE)
        else $error("eviction without fault");

    // Never ready for input while a result is pending.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");

endmodule
